[hdl/ihex_pkg.sv]
`default_nettype none

package ihex_pkg;

    // bytes per data record
    localparam int LINE_BYTES = 16;
    // width of the record byte count, holds LINE_BYTES itself
    localparam int CNT_W = $clog2(LINE_BYTES + 1);
    // width of an index into the record buffer
    localparam int IDX_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    // width of the digit position counter
    localparam int POS_W = 4;
    // characters in the end record including CR LF
    localparam int END_LEN = 13;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // character source chosen by the controller
    typedef enum logic [3:0] {
        SEL_COLON,
        SEL_LEN,
        SEL_ADDR,
        SEL_TYPE,
        SEL_DATA,
        SEL_CHK,
        SEL_CR,
        SEL_LF,
        SEL_END
    } t_sel;

    typedef struct packed {
        logic             take;    // input beat accepted this cycle
        logic             emit;    // load a character into the output register
        t_sel             sel;
        logic [POS_W-1:0] pos;     // digit position within the field
        logic             last;    // final character for the current input beat
        logic             clear;   // record sent, empty the line
        logic [IDX_W-1:0] rd_idx;  // buffer read address for the next cycle
    } t_cmd;

    typedef struct packed {
        logic             room;       // output register can take a character
        logic             close;      // data beat at the input closes a record
        logic             have_data;  // line holds at least one byte
        logic [CNT_W-1:0] count;
    } t_status;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] v;
        v = {4'h0, nib};
        if (nib < 4'd10) begin
            return CH_ZERO + v;
        end else begin
            return 8'h37 + v;
        end
    endfunction

    // ":00000001FF" CR LF
    function automatic logic [7:0] end_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            4'd0:    c = CH_COLON;
            4'd8:    c = CH_ONE;
            4'd9:    c = CH_F;
            4'd10:   c = CH_F;
            4'd11:   c = CH_CR;
            4'd12:   c = CH_LF;
            default: c = CH_ZERO;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/ihex_dp.sv]
`default_nettype none

module ihex_dp (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire ihex_pkg::t_cmd        i_cmd,
    output ihex_pkg::t_status          o_status,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic [15:0]           i_byte_address,
    input  wire logic                  i_section_end,
    input  wire logic                  i_kind,
    input  wire logic                  i_out_stall,
    output logic                       o_out_valid,
    output logic [7:0]                 o_character,
    output logic                       o_run_last
);
    import ihex_pkg::*;

    logic [7:0]       r_line [LINE_BYTES];
    logic [7:0]       r_rd_byte;
    logic [CNT_W-1:0] r_count;
    logic [15:0]      r_start;
    logic [7:0]       r_sum;
    logic             r_out_valid;
    logic [7:0]       r_char;
    logic             r_last;

    logic [7:0] len_byte;
    logic [7:0] chk;
    logic [7:0] ch;
    logic [3:0] nib;

    assign len_byte = 8'(r_count);
    assign chk      = 8'h00 - (r_sum + len_byte + r_start[15:8] + r_start[7:0]);

    always_comb begin
        nib = 4'h0;
        ch  = CH_ZERO;
        unique case (i_cmd.sel)
            SEL_COLON: ch = CH_COLON;
            SEL_LEN: begin
                nib = i_cmd.pos[0] ? len_byte[3:0] : len_byte[7:4];
                ch  = hex_char(nib);
            end
            SEL_ADDR: begin
                unique case (i_cmd.pos[1:0])
                    2'd0: nib = r_start[15:12];
                    2'd1: nib = r_start[11:8];
                    2'd2: nib = r_start[7:4];
                    2'd3: nib = r_start[3:0];
                endcase
                ch = hex_char(nib);
            end
            SEL_TYPE: ch = CH_ZERO;
            SEL_DATA: begin
                nib = i_cmd.pos[0] ? r_rd_byte[3:0] : r_rd_byte[7:4];
                ch  = hex_char(nib);
            end
            SEL_CHK: begin
                nib = i_cmd.pos[0] ? chk[3:0] : chk[7:4];
                ch  = hex_char(nib);
            end
            SEL_CR:  ch = CH_CR;
            SEL_LF:  ch = CH_LF;
            SEL_END: ch = end_char(i_cmd.pos);
            default: ch = CH_ZERO;
        endcase
    end

    // record buffer, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.take && i_kind == KIND_DATA) begin
            r_line[r_count[IDX_W-1:0]] <= i_data_byte;
        end
        r_rd_byte <= r_line[i_cmd.rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_start     <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
            r_char      <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_sum   <= '0;
            end else if (i_cmd.take && i_kind == KIND_DATA) begin
                if (r_count == '0) begin
                    r_start <= i_byte_address;
                end
                r_count <= r_count + CNT_W'(1);
                r_sum   <= r_sum + i_data_byte;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_char      <= ch;
                r_last      <= i_cmd.last;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.room      = !r_out_valid || !i_out_stall;
    assign o_status.close     = (r_count == CNT_W'(LINE_BYTES - 1)) || i_section_end;
    assign o_status.have_data = (r_count != '0);
    assign o_status.count     = r_count;

    assign o_out_valid = r_out_valid;
    assign o_character = r_char;
    assign o_run_last  = r_last;

endmodule

`default_nettype wire

[hdl/ihex_ctrl.sv]
`default_nettype none

module ihex_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_kind,
    output logic                    o_in_stall,
    input  wire ihex_pkg::t_status  i_status,
    output ihex_pkg::t_cmd          o_cmd
);
    import ihex_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COLON,
        S_LEN,
        S_ADDR,
        S_TYPE,
        S_DATA,
        S_CHK,
        S_CR,
        S_LF,
        S_END
    } t_state;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_step, n_step;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic             r_fin, n_fin;

    logic take;
    logic adv;
    logic last_byte;

    assign take      = i_in_valid && (r_state == S_IDLE);
    assign adv       = (r_state != S_IDLE) && i_status.room;
    assign last_byte = (CNT_W'(r_idx) + CNT_W'(1)) == i_status.count;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_idx   = r_idx;
        n_fin   = r_fin;
        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                n_idx  = '0;
                if (take) begin
                    if (i_kind == KIND_FINISH) begin
                        n_fin   = 1'b1;
                        n_state = i_status.have_data ? S_COLON : S_END;
                    end else if (i_status.close) begin
                        n_fin   = 1'b0;
                        n_state = S_COLON;
                    end
                end
            end
            S_COLON: if (adv) n_state = S_LEN;
            S_LEN: begin
                if (adv) begin
                    n_step = r_step + POS_W'(1);
                    if (r_step[0]) begin
                        n_step  = '0;
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                if (adv) begin
                    n_step = r_step + POS_W'(1);
                    if (r_step[1:0] == 2'd3) begin
                        n_step  = '0;
                        n_state = S_TYPE;
                    end
                end
            end
            S_TYPE: begin
                if (adv) begin
                    n_step = r_step + POS_W'(1);
                    if (r_step[0]) begin
                        n_step  = '0;
                        n_state = S_DATA;
                    end
                end
            end
            S_DATA: begin
                if (adv) begin
                    n_step = r_step + POS_W'(1);
                    if (r_step[0]) begin
                        n_step = '0;
                        if (last_byte) begin
                            n_state = S_CHK;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                        end
                    end
                end
            end
            S_CHK: begin
                if (adv) begin
                    n_step = r_step + POS_W'(1);
                    if (r_step[0]) begin
                        n_step  = '0;
                        n_state = S_CR;
                    end
                end
            end
            S_CR: if (adv) n_state = S_LF;
            S_LF: begin
                if (adv) begin
                    n_step  = '0;
                    n_state = r_fin ? S_END : S_IDLE;
                end
            end
            S_END: begin
                if (adv) begin
                    n_step = r_step + POS_W'(1);
                    if (r_step == POS_W'(END_LEN - 1)) begin
                        n_step  = '0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
            r_idx   <= '0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_idx   <= n_idx;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        o_cmd.take   = take;
        o_cmd.emit   = adv;
        o_cmd.pos    = r_step;
        o_cmd.rd_idx = n_idx;
        o_cmd.clear  = adv && (r_state == S_LF);
        o_cmd.last   = 1'b0;
        o_cmd.sel    = SEL_COLON;
        unique case (r_state)
            S_IDLE:  o_cmd.sel = SEL_COLON;
            S_COLON: o_cmd.sel = SEL_COLON;
            S_LEN:   o_cmd.sel = SEL_LEN;
            S_ADDR:  o_cmd.sel = SEL_ADDR;
            S_TYPE:  o_cmd.sel = SEL_TYPE;
            S_DATA:  o_cmd.sel = SEL_DATA;
            S_CHK:   o_cmd.sel = SEL_CHK;
            S_CR:    o_cmd.sel = SEL_CR;
            S_LF: begin
                o_cmd.sel  = SEL_LF;
                o_cmd.last = !r_fin;
            end
            S_END: begin
                o_cmd.sel  = SEL_END;
                o_cmd.last = (r_step == POS_W'(END_LEN - 1));
            end
            default: o_cmd.sel = SEL_COLON;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[hdl/intel_hex_record_encoder.sv]
`default_nettype none

// Intel HEX record writer. Each input beat carries either one section byte
// (kind 0) with its 16-bit load address and a last-of-section mark, or a
// finish request (kind 1). Bytes collect in a line buffer of LINE_BYTES
// entries; the record address is that of the first byte in the line, later
// addresses are ignored. When the line fills, or a byte carries the section
// end mark, the block streams ':' LL AAAA 00 DD.. CC CR LF as ASCII, one
// character per output beat, upper-case hex and two's-complement checksum.
// A finish beat first flushes any partial line and then sends the end
// record ":00000001FF" CR LF. o_run_last marks the last character caused by
// one input beat. Timing: a byte that does not close a line does not hold
// the input off; a byte that closes a line of N bytes holds the input off
// while its 2N + 13 characters go out, one character per cycle from the
// output register while the consumer does not stall; a finish beat adds 13
// more characters for the end record. The character emitter sets the rate.
module intel_hex_record_encoder (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input beat
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [15:0] i_byte_address,
    input  wire logic        i_section_end,
    // output beat, one ascii character
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_character,
    output logic             o_run_last
);
    import ihex_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: walks the record fields and the end record
    ihex_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // line buffer, count, start address, checksum and output register
    ihex_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_data_byte    (i_data_byte),
        .i_byte_address (i_byte_address),
        .i_section_end  (i_section_end),
        .i_kind         (i_kind),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_character    (o_character),
        .o_run_last     (o_run_last)
    );

endmodule

`default_nettype wire

[bench/testbench.sv]
`default_nettype none

// checks the ascii text of the hex record writer against its own model of
// the line buffer, record address and checksum
class hex_text_scoreboard;
    logic [7:0]  line_buf [ihex_pkg::LINE_BYTES];
    int unsigned fill;
    logic [15:0] rec_addr;
    logic [7:0]  byte_sum;
    logic [7:0]  want_char [$];
    logic        want_last [$];
    int unsigned errors;
    int unsigned records;
    int unsigned end_records;
    int unsigned chars_checked;

    function new();
        fill = 0;
        rec_addr = '0;
        byte_sum = '0;
        errors = 0;
        records = 0;
        end_records = 0;
        chars_checked = 0;
    endfunction

    function void push_char(input logic [7:0] c);
        want_char.push_back(c);
        want_last.push_back(1'b0);
    endfunction

    function void push_hex(input logic [7:0] v);
        logic [3:0] nib;
        for (int h = 1; h >= 0; h--) begin
            nib = h ? v[7:4] : v[3:0];
            push_char(nib < 4'd10 ? ihex_pkg::CH_ZERO + 8'(nib) : 8'h41 + 8'(nib) - 8'd10);
        end
    endfunction

    function void emit_data_record();
        logic [7:0] total;
        total = byte_sum + 8'(fill) + rec_addr[15:8] + rec_addr[7:0];
        push_char(ihex_pkg::CH_COLON);
        push_hex(8'(fill));
        push_hex(rec_addr[15:8]);
        push_hex(rec_addr[7:0]);
        push_hex(8'h00);
        for (int i = 0; i < fill; i++) push_hex(line_buf[i]);
        push_hex(8'h00 - total);
        push_char(ihex_pkg::CH_CR);
        push_char(ihex_pkg::CH_LF);
        fill = 0;
        byte_sum = '0;
        records++;
    endfunction

    // work out the text caused by one accepted input beat
    function void note_beat(input logic k, input logic [7:0] d, input logic [15:0] a,
                            input logic e);
        string end_text;
        int unsigned before_cnt;
        end_text = ":00000001FF";
        before_cnt = want_char.size();
        if (k == ihex_pkg::KIND_DATA) begin
            if (fill == 0) rec_addr = a;
            if (fill < ihex_pkg::LINE_BYTES) begin
                line_buf[fill] = d;
                fill++;
                byte_sum = byte_sum + d;
            end
            if (fill >= ihex_pkg::LINE_BYTES || e) emit_data_record();
        end else begin
            if (fill != 0) emit_data_record();
            for (int i = 0; i < end_text.len(); i++) push_char(end_text[i]);
            push_char(ihex_pkg::CH_CR);
            push_char(ihex_pkg::CH_LF);
            end_records++;
        end
        if (want_char.size() > before_cnt) want_last[want_last.size() - 1] = 1'b1;
    endfunction

    function void check_char(input logic [7:0] c, input logic l);
        logic [7:0] exp_c;
        logic       exp_l;
        chars_checked++;
        if (want_char.size() == 0) begin
            $display("%0t: unexpected character %h run_last %b", $time, c, l);
            errors++;
            return;
        end
        exp_c = want_char.pop_front();
        exp_l = want_last.pop_front();
        if (c !== exp_c) begin
            $display("%0t: character expected %h actual %h", $time, exp_c, c);
            errors++;
        end
        if (l !== exp_l) begin
            $display("%0t: run_last expected %b actual %b", $time, exp_l, l);
            errors++;
        end
    endfunction

    function int unsigned outstanding();
        return want_char.size();
    endfunction
endclass

module testbench;
    import ihex_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_kind;
    logic [7:0]  i_data_byte;
    logic [15:0] i_byte_address;
    logic        i_section_end;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_character;
    logic        o_run_last;

    hex_text_scoreboard sb;

    // both sides stop idling while calm is set
    logic        calm;
    int unsigned beats_sent;
    int unsigned chars_seen;
    int unsigned stall_hold;

    intel_hex_record_encoder uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_kind         (i_kind),
        .i_data_byte    (i_data_byte),
        .i_byte_address (i_byte_address),
        .i_section_end  (i_section_end),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_character    (o_character),
        .o_run_last     (o_run_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #(10 * 1_000_000);
        $display("FAILURE");
        $finish;
    end

    // one input beat: random idle gap, then hold the beat until the block takes it;
    // called and returns at a falling edge
    task automatic send_beat(input logic k, input logic [7:0] d, input logic [15:0] a,
                             input logic e);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     = 1'b1;
        i_kind         = k;
        i_data_byte    = d;
        i_byte_address = a;
        i_section_end  = e;
        // accepted at the first rising edge with the stall low
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(k, d, a, e);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // a run of contiguous bytes, the last one marked as end of section
    task automatic send_section(input int unsigned len, input logic [15:0] base);
        for (int i = 0; i < len; i++) begin
            send_beat(KIND_DATA, 8'($urandom), base + 16'(i), i == len - 1);
        end
    endtask

    // receiving side: check each character, then stall for a random stretch
    initial begin
        stall_hold  = 0;
        chars_seen  = 0;
        i_out_stall = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_char(o_character, o_run_last);
                chars_seen++;
                // one long hold-off so the input backs up
                if (chars_seen == 200) begin
                    stall_hold = 400;
                end else begin
                    stall_hold = calm ? 0 : $urandom_range(0, 8);
                end
            end
            @(negedge i_clk);
            if (stall_hold > 0) begin
                i_out_stall = 1'b1;
                stall_hold--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    // sending side and end of run
    initial begin
        int unsigned rand_items;
        int unsigned pick;
        int unsigned len;
        logic [15:0] base;

        sb = new();
        calm           = 1'b0;
        beats_sent     = 0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_kind         = KIND_DATA;
        i_data_byte    = '0;
        i_byte_address = '0;
        i_section_end  = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // finish with an empty line: end record alone
        send_beat(KIND_FINISH, 8'hFF, 16'hFFFF, 1'b1);
        // one-byte records at both address extremes, byte extremes
        send_beat(KIND_DATA, 8'h00, 16'h0000, 1'b1);
        send_beat(KIND_DATA, 8'hFF, 16'hFFFF, 1'b1);
        // full line closed by count alone; later addresses are junk and ignored
        for (int i = 0; i < LINE_BYTES; i++) begin
            send_beat(KIND_DATA, (i % 2) ? 8'hA5 : 8'h5A,
                      (i == 0) ? 16'h1234 : 16'($urandom), 1'b0);
        end
        // partial line flushed by finish
        send_beat(KIND_DATA, 8'h80, 16'hFFFE, 1'b0);
        send_beat(KIND_DATA, 8'h7F, 16'hFFFF, 1'b0);
        send_beat(KIND_DATA, 8'h01, 16'h0000, 1'b0);
        send_beat(KIND_FINISH, 8'h00, 16'h0000, 1'b0);

        // random part: mostly well-formed sections, some lone bytes and finishes
        rand_items = 0;
        while (rand_items < 196) begin
            // a stretch with no idling on either side
            calm = (rand_items >= 90 && rand_items < 140);
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_beat(KIND_FINISH, 8'($urandom), 16'($urandom), 1'($urandom));
                rand_items++;
            end else if (pick == 1) begin
                send_beat(KIND_DATA, 8'($urandom), 16'($urandom), 1'($urandom));
                rand_items++;
            end else begin
                len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                   : $urandom_range(1, 16);
                // some sections run across the top of the address space
                base = ($urandom_range(0, 3) == 0) ? 16'hFFF8 + 16'($urandom_range(0, 7))
                                                   : 16'($urandom);
                send_section(len, base);
                rand_items += len;
            end
        end
        calm = 1'b0;
        // flush whatever is left in the line
        send_beat(KIND_FINISH, 8'($urandom), 16'($urandom), 1'b0);
        i_in_valid = 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        // catch any stray character after the last expected one
        repeat (40) @(posedge i_clk);

        $display("covered %0d input beats, %0d data records and %0d end records",
                 beats_sent, sb.records, sb.end_records);
        $display("checked %0d characters, %0d mismatches", sb.chars_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
hdl/ihex_pkg.sv
hdl/ihex_dp.sv
hdl/ihex_ctrl.sv
hdl/intel_hex_record_encoder.sv
bench/testbench.sv
